/* rtl/core/sbb_pkg.sv */
// Package for the spectrum bin brightness block: controller states, command and
// status structs, decay coefficients and the gamma table.
// No dependencies.
package sbb_pkg;

  // Q0.16 decay factors: 0.95 for the peak, 0.9 for the level
  localparam logic [15:0] PEAK_DECAY_Q16  = 16'd62259;
  localparam logic [15:0] LEVEL_DECAY_Q16 = 16'd58982;

  // Quotient bits of the normalizing divide
  localparam int unsigned DIV_STEPS = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_PEAK,
    ST_MUL_LEVEL,
    ST_UPD_LEVEL,
    ST_WRITE,
    ST_DIV,
    ST_LUT,
    ST_OUT
  } sbb_state_e;

  typedef struct packed {
    logic load_in;
    logic read;
    logic mul_peak;
    logic mul_level;
    logic upd_level;
    logic write;
    logic div_step;
    logic lut;
    logic load_out;
  } sbb_cmd_t;

  typedef struct packed {
    logic out_free;
  } sbb_stat_t;

  typedef logic [255:0][7:0] gamma_tbl_t;

  // gamma[i] = floor(255 * (i/255)^(5/3)), exact integer form:
  // the largest k with k^3 * 255^2 <= i^5
  function automatic gamma_tbl_t gamma_build();
    gamma_tbl_t        tbl;
    longint unsigned   k;
    longint unsigned   p;
    longint unsigned   ii;
    tbl = '0;
    k   = 0;
    for (int i = 0; i < 256; i++) begin
      ii = longint'(i);
      p  = ii * ii * ii * ii * ii;
      while (k < 255 && (k + 1) * (k + 1) * (k + 1) * 65025 <= p) begin
        k = k + 1;
      end
      tbl[i] = 8'(k);
    end
    return tbl;
  endfunction

  localparam gamma_tbl_t GAMMA_TBL = gamma_build();

endpackage

/* rtl/core/sbb_ifs.sv */
// Valid/ready channel interfaces for the spectrum bin brightness block:
// one for bin words in, one for brightness words out. No dependencies.
interface sbb_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         bin_index;
  logic signed [15:0] bin_level;

  modport source (output valid, output bin_index, output bin_level, input ready);
  modport sink   (input valid, input bin_index, input bin_level, output ready);
endinterface

interface sbb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_bin_index;
  logic [7:0] brightness;

  modport source (output valid, output out_bin_index, output brightness, input ready);
  modport sink   (input valid, input out_bin_index, input brightness, output ready);
endinterface

/* rtl/core/sbb_ctrl.sv */
// Controller for the spectrum bin brightness block: sequences read, decay,
// update, write, divide, lookup and output steps. Depends on sbb_pkg.
module sbb_ctrl
  import sbb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sbb_stat_t stat_i,
  output sbb_cmd_t  cmd_o
);

  sbb_state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_READ;
      ST_READ:      state_d = ST_MUL_PEAK;
      ST_MUL_PEAK:  state_d = ST_MUL_LEVEL;
      ST_MUL_LEVEL: state_d = ST_UPD_LEVEL;
      ST_UPD_LEVEL: state_d = ST_WRITE;
      ST_WRITE: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'(DIV_STEPS - 1)) state_d = ST_LUT;
      end
      ST_LUT:       state_d = ST_OUT;
      ST_OUT:       if (stat_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_READ:      cmd_o.read      = 1'b1;
      ST_MUL_PEAK:  cmd_o.mul_peak  = 1'b1;
      ST_MUL_LEVEL: cmd_o.mul_level = 1'b1;
      ST_UPD_LEVEL: cmd_o.upd_level = 1'b1;
      ST_WRITE:     cmd_o.write     = 1'b1;
      ST_DIV:       cmd_o.div_step  = 1'b1;
      ST_LUT:       cmd_o.lut       = 1'b1;
      ST_OUT:       cmd_o.load_out  = stat_i.out_free;
      default:      cmd_o           = '0;
    endcase
  end

endmodule

/* rtl/core/sbb_datapath.sv */
// Datapath for the spectrum bin brightness block: per-bin peak and level
// memories, shared decay multiplier, serial divider, gamma lookup and output
// register. Depends on sbb_pkg.
module sbb_datapath
  import sbb_pkg::*;
#(
  parameter int NUM_BINS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbb_cmd_t           cmd_i,
  output sbb_stat_t          stat_o,
  input  logic [7:0]         bin_index_i,
  input  logic signed [15:0] bin_level_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         out_bin_index_o,
  output logic [7:0]         brightness_o
);

  // The index field is 8 bits, so no more than 256 bins are ever addressed
  localparam int          DEPTH = (NUM_BINS < 256) ? NUM_BINS : 256;
  localparam int          AW    = $clog2(DEPTH);
  localparam logic [10:0] NB    = 11'(NUM_BINS);

  function automatic logic [16:0] mag17(input logic signed [15:0] v);
    return v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
  endfunction

  function automatic logic signed [15:0] apply_sign(input logic neg,
                                                    input logic [32:0] prod);
    return neg ? (16'sd0 - $signed(prod[31:16])) : $signed(prod[31:16]);
  endfunction

  logic signed [15:0] peak_mem  [DEPTH];
  logic signed [15:0] level_mem [DEPTH];
  logic [DEPTH-1:0]   vld_q;

  logic [7:0]         idx_q;
  logic signed [15:0] lvl_q;
  logic               in_range_q;
  logic signed [15:0] peak_rd_q, level_rd_q;
  logic [32:0]        prod_q;
  logic signed [15:0] peak_new_q, level_new_q;
  logic [23:0]        rem_q, dsh_q;
  logic [7:0]         quo_q;
  logic               sat_q, zero_q;
  logic [7:0]         bright_q;
  logic               out_valid_q;
  logic [7:0]         out_idx_q, out_bright_q;

  logic [AW-1:0]      addr;
  logic [16:0]        mul_a;
  logic [15:0]        mul_c;
  logic [23:0]        num;
  logic [23:0]        peak_x256;
  logic [23:0]        rem_diff;
  logic               rem_ge;

  assign addr = idx_q[AW-1:0];

  // One shared multiplier: peak decay first, level decay next
  assign mul_a = cmd_i.mul_level ? mag17(level_rd_q) : mag17(peak_rd_q);
  assign mul_c = cmd_i.mul_level ? LEVEL_DECAY_Q16 : PEAK_DECAY_Q16;

  // level*255 and peak*256, both positive when used
  assign num       = {1'b0, level_new_q[14:0], 8'd0} - {9'd0, level_new_q[14:0]};
  assign peak_x256 = {1'b0, peak_new_q[14:0], 8'd0};

  assign rem_diff = rem_q - dsh_q;
  assign rem_ge   = (rem_q >= dsh_q);

  // Valid bits stand in for clearing the memories at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.write && in_range_q) begin
      vld_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && in_range_q) begin
      peak_mem[addr]  <= peak_new_q;
      level_mem[addr] <= level_new_q;
    end
    if (cmd_i.read) begin
      peak_rd_q  <= vld_q[addr] ? peak_mem[addr]  : 16'sd0;
      level_rd_q <= vld_q[addr] ? level_mem[addr] : 16'sd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      idx_q      <= bin_index_i;
      lvl_q      <= bin_level_i;
      in_range_q <= ({3'b000, bin_index_i} < NB);
    end
    if (cmd_i.mul_peak || cmd_i.mul_level) begin
      prod_q <= 33'(mul_a) * 33'(mul_c);
    end
    if (cmd_i.mul_level) begin
      peak_new_q <= (lvl_q > peak_rd_q) ? lvl_q : apply_sign(peak_rd_q[15], prod_q);
    end
    if (cmd_i.upd_level) begin
      if (!lvl_q[15] && lvl_q != 16'sd0 && lvl_q > level_rd_q) begin
        level_new_q <= lvl_q;
      end else if (lvl_q < level_rd_q) begin
        level_new_q <= apply_sign(level_rd_q[15], prod_q);
      end else begin
        level_new_q <= level_rd_q;
      end
    end
    if (cmd_i.write) begin
      rem_q  <= num;
      dsh_q  <= peak_x256 >> 1;
      quo_q  <= '0;
      sat_q  <= (num >= peak_x256);
      zero_q <= !in_range_q || peak_new_q[15] || peak_new_q == 16'sd0
                || level_new_q[15] || level_new_q == 16'sd0;
    end
    if (cmd_i.div_step) begin
      if (rem_ge) rem_q <= rem_diff;
      quo_q <= {quo_q[6:0], rem_ge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.lut) begin
      bright_q <= zero_q ? 8'd0 : GAMMA_TBL[sat_q ? 8'hFF : quo_q];
    end
    if (cmd_i.load_out) begin
      out_idx_q    <= idx_q;
      out_bright_q <= bright_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_bin_index_o  = out_idx_q;
  assign brightness_o     = out_bright_q;

endmodule

/* rtl/core/spectrum_bin_level_to_brightness.sv */
// Top level of the spectrum bin brightness block: controller plus datapath.
// Depends on sbb_pkg, sbb_in_if, sbb_out_if, sbb_ctrl and sbb_datapath.
//
//   channel  | dir | payload                               | handshake
//   ---------+-----+---------------------------------------+------------
//   in_i     | in  | bin_index[7:0], bin_level[15:0] Q8.8  | valid/ready
//   out_o    | out | out_bin_index[7:0], brightness[7:0]   | valid/ready
//
// Each word goes through these steps in order: accept in the idle state,
// then memory read, two decay multiplies on the one shared
// multiplier, update, store write, eight steps of the serial divider, gamma
// lookup and output load.
// Reset leaves all bins with peak and level zero; per-bin valid bits do
// this at once, so no clearing pass runs and a word is taken right away.
// A finished word sits in the output register while the next word is
// accepted; only a second result finding that register full holds the
// controller in its output step until the sink takes the first.
module spectrum_bin_level_to_brightness
  import sbb_pkg::*;
#(
  parameter int NUM_BINS = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sbb_in_if.sink   in_i,
  sbb_out_if.source out_o
);

  sbb_cmd_t  cmd;
  sbb_stat_t stat;

  // Step the work through the datapath
  sbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the per-bin state and compute the brightness
  sbb_datapath #(
    .NUM_BINS (NUM_BINS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .bin_index_i     (in_i.bin_index),
    .bin_level_i     (in_i.bin_level),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_bin_index_o (out_o.out_bin_index),
    .brightness_o    (out_o.brightness)
  );

  // One word at a time: no second word right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a word is in progress");

  // Never overwrite a result the sink has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_o.valid || out_o.ready))
    else $error("output register loaded while still full");

  // A result shows up only from a load
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.load_out))
    else $error("output valid without a load");

endmodule
